// ===== hw/rtl/signature_intern_table_assert.svh =====
// Assertion macros used by the signature intern table RTL.
`ifndef SIGNATURE_INTERN_TABLE_ASSERT_SVH
`define SIGNATURE_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("signature intern table: assertion failed");

// Next-cycle implication, checked out of reset.
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("signature intern table: assertion failed");

`endif

// ===== hw/rtl/sit_pkg.sv =====
`timescale 1ns / 1ps
package sit_pkg;

   localparam int SIG_ENTRIES = 256;
   localparam int MAX_ARGS    = 8;
   localparam int IDX_W       = $clog2(SIG_ENTRIES);
   localparam int CNT_W       = $clog2(SIG_ENTRIES + 1);
   localparam int LANES       = 8;
   localparam int HDR_W       = 13;
   localparam int ARGS_W      = 8 * LANES;

   typedef struct packed {
      logic [7:0] return_type;
      logic [3:0] param_count;
      logic       varargs;
      logic [7:0] arg_0;
      logic [7:0] arg_1;
      logic [7:0] arg_2;
      logic [7:0] arg_3;
      logic [7:0] arg_4;
      logic [7:0] arg_5;
      logic [7:0] arg_6;
      logic [7:0] arg_7;
   } sit_req_type;

   typedef struct packed {
      logic [7:0] sig_index;
      logic       table_full;
   } sit_rsp_type;

   // Normalized signature broadcast to every cell during a scan.
   typedef struct packed {
      logic [HDR_W-1:0]  header;
      logic [ARGS_W-1:0] args;
   } sit_query_type;

   // Scan token handed from cell to cell.
   typedef struct packed {
      logic             active;
      logic             done;
      logic             inserted;
      logic [IDX_W-1:0] index;
   } sit_token_type;

   function automatic logic [7:0] to_sig_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+7:0] wide;
      wide = {8'b0, idx};
      return wide[7:0];
   endfunction

endpackage

// ===== hw/rtl/sit_cell.sv =====
`timescale 1ns / 1ps
module sit_cell import sit_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     cell_idx,
   input  logic [CNT_W-1:0]     entry_count,
   input  sit_query_type        query,
   input  sit_token_type        prev_tok,
   output sit_token_type        next_tok
);

   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [ARGS_W-1:0] args_ff, args_in;
   sit_token_type     tok_ff, tok_in;

   logic [CNT_W-1:0] idx_ext;
   logic             scan;
   logic             live;
   logic             at_free;
   logic             hit;

   always_comb begin
      idx_ext = CNT_W'(cell_idx);
      scan    = prev_tok.active && !prev_tok.done;
      live    = idx_ext < entry_count;
      at_free = idx_ext == entry_count;
      // stored args are already masked by their own count, so a header match
      // makes a plain compare exact
      hit     = live && (hdr_ff == query.header) && (args_ff == query.args);

      tok_in  = prev_tok;
      hdr_in  = hdr_ff;
      args_in = args_ff;
      if (scan && (hit || at_free)) begin
         tok_in.done  = 1'b1;
         tok_in.index = cell_idx;
      end
      if (scan && at_free) begin
         tok_in.inserted = 1'b1;
         hdr_in          = query.header;
         args_in         = query.args;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.done     <= tok_in.done;
      tok_ff.inserted <= tok_in.inserted;
      tok_ff.index    <= tok_in.index;
      hdr_ff          <= hdr_in;
      args_ff         <= args_in;
   end

   assign next_tok = tok_ff;

endmodule

// ===== hw/rtl/signature_intern_table.sv =====
// An accepted request is registered into start_ff and query_ff, then launched down the cell chain.
// The scan token walks the cell chain one cell per cycle, so every lookup takes the full chain.
// req_ready stays low until a result enters the output register; a new request is then taken
// while the previous response still waits, and its result parks until the output register frees.
// Reset clears the entry count and all control state; stored entries are left undefined
// and need no clearing pass.
`timescale 1ns / 1ps
`include "signature_intern_table_assert.svh"
module signature_intern_table import sit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sit_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sit_rsp_type rsp_payload
);

   logic          busy_ff, busy_in;
   logic          start_ff, start_in;
   sit_query_type query_ff, query_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sit_rsp_type   rsp_ff, rsp_in;
   logic          tail_valid_ff, tail_valid_in;
   sit_rsp_type   tail_ff, tail_in;

   sit_token_type launch_tok;
   sit_token_type chain_tok [SIG_ENTRIES];
   sit_token_type exit_tok;
   sit_rsp_type   exit_rsp;
   logic          req_fire;
   logic          rsp_free;
   logic [7:0]    lanes [LANES];
   logic [3:0]    cnt_sat;
   logic [ARGS_W-1:0] args_norm;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      launch_tok          = '0;
      launch_tok.active   = start_ff;
   end

   for (genvar g = 0; g < SIG_ENTRIES; g++) begin : g_cell
      sit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(g)),
         .entry_count (count_ff),
         .query       (query_ff),
         .prev_tok    ((g == 0) ? launch_tok : chain_tok[(g == 0) ? 0 : g - 1]),
         .next_tok    (chain_tok[g])
      );
   end

   assign exit_tok = chain_tok[SIG_ENTRIES-1];

   always_comb begin
      exit_rsp.sig_index  = exit_tok.done ? to_sig_index(exit_tok.index) : 8'd0;
      exit_rsp.table_full = !exit_tok.done;
   end

   // normalize: saturate the count, zero the unused lanes
   always_comb begin
      lanes[0] = req_payload.arg_0;
      lanes[1] = req_payload.arg_1;
      lanes[2] = req_payload.arg_2;
      lanes[3] = req_payload.arg_3;
      lanes[4] = req_payload.arg_4;
      lanes[5] = req_payload.arg_5;
      lanes[6] = req_payload.arg_6;
      lanes[7] = req_payload.arg_7;
      cnt_sat  = (req_payload.param_count > 4'(MAX_ARGS)) ? 4'(MAX_ARGS)
                                                           : req_payload.param_count;
      args_norm = '0;
      for (int l = 0; l < LANES; l++) begin
         if (4'(l) < cnt_sat) begin
            args_norm[8*l +: 8] = lanes[l];
         end
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      start_in      = 1'b0;
      query_in      = query_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      tail_valid_in = tail_valid_ff;
      tail_in       = tail_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // drain the parked result once the output register frees
      if (tail_valid_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = tail_ff;
         tail_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
      if (exit_tok.active) begin
         if (exit_tok.inserted) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = exit_rsp;
            busy_in      = 1'b0;
         end else begin
            tail_valid_in = 1'b1;
            tail_in       = exit_rsp;
         end
      end
      if (req_fire) begin
         busy_in         = 1'b1;
         start_in        = 1'b1;
         query_in.header = {req_payload.return_type, cnt_sat, req_payload.varargs};
         query_in.args   = args_norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         start_ff      <= start_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      query_ff <= query_in;
      rsp_ff   <= rsp_in;
      tail_ff  <= tail_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SIT_ASSERT_NOW(a_exit_in_flight, clock, reset, exit_tok.active, busy_ff)
   `SIT_ASSERT_NOW(a_tail_behind_rsp, clock, reset, tail_valid_ff, rsp_valid_ff && busy_ff)
   `SIT_ASSERT_NOW(a_full_only_at_limit, clock, reset, exit_tok.active && !exit_tok.done,
                   count_ff == CNT_W'(SIG_ENTRIES))
   `SIT_ASSERT_NEXT(a_insert_bumps_count, clock, reset, exit_tok.active && exit_tok.inserted,
                    count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench import sit_pkg::*; ();

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sit_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sit_rsp_type rsp_payload;

   signature_intern_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Lookup takes the whole cell chain plus the output register.
   localparam int LOOKUP_CYCLES = SIG_ENTRIES + 1;

   // Mirror of the table contents.
   logic [HDR_W-1:0]  known_header [SIG_ENTRIES];
   logic [ARGS_W-1:0] known_args   [SIG_ENTRIES];
   int                known_count;

   sit_rsp_type pending_rsp_q[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int sent_total;
   int hit_total;
   int insert_total;
   int full_total;
   int checked_total;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Timeout with %0d results still pending", pending_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [ARGS_W-1:0] lane_enable(input logic [3:0] cnt);
      logic [ARGS_W-1:0] m;
      m = '0;
      for (int i = 0; i < LANES; i++) begin
         if (i < cnt) m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [3:0] clamp_count(input logic [3:0] cnt);
      return (cnt > 4'(MAX_ARGS)) ? 4'(MAX_ARGS) : cnt;
   endfunction

   function automatic logic [ARGS_W-1:0] arg_lanes(input sit_req_type s);
      return {s.arg_7, s.arg_6, s.arg_5, s.arg_4, s.arg_3, s.arg_2, s.arg_1, s.arg_0};
   endfunction

   function automatic sit_req_type make_sig(input logic [7:0] ret, input logic [3:0] cnt,
                                            input logic var_flag,
                                            input logic [ARGS_W-1:0] a);
      sit_req_type s;
      s.return_type = ret;
      s.param_count = cnt;
      s.varargs     = var_flag;
      s.arg_0 = a[7:0];
      s.arg_1 = a[15:8];
      s.arg_2 = a[23:16];
      s.arg_3 = a[31:24];
      s.arg_4 = a[39:32];
      s.arg_5 = a[47:40];
      s.arg_6 = a[55:48];
      s.arg_7 = a[63:56];
      return s;
   endfunction

   // Find-or-insert against the mirror; advance the mirror on an insert.
   function automatic sit_rsp_type intern_signature(input sit_req_type s);
      logic [3:0]        cnt;
      logic [ARGS_W-1:0] a;
      logic [HDR_W-1:0]  hdr;
      sit_rsp_type       r;
      cnt = clamp_count(s.param_count);
      a   = arg_lanes(s) & lane_enable(cnt);
      hdr = {s.return_type, cnt, s.varargs};
      r   = '0;
      for (int i = 0; i < known_count; i++) begin
         if (known_header[i] == hdr && known_args[i] == a) begin
            r.sig_index = 8'(i);
            hit_total++;
            return r;
         end
      end
      if (known_count >= SIG_ENTRIES) begin
         r.table_full = 1'b1;
         full_total++;
         return r;
      end
      known_header[known_count] = hdr;
      known_args[known_count]   = a;
      r.sig_index = 8'(known_count);
      known_count++;
      insert_total++;
      return r;
   endfunction

   // Scramble the ignored lanes and, at full count, the saturating count bits.
   function automatic sit_req_type add_lane_noise(input sit_req_type s);
      logic [3:0]        cnt;
      logic [ARGS_W-1:0] m;
      logic [ARGS_W-1:0] a;
      cnt = clamp_count(s.param_count);
      m   = lane_enable(cnt);
      a   = (arg_lanes(s) & m) | ({$urandom, $urandom} & ~m);
      if (cnt == 4'(MAX_ARGS) && $urandom_range(1)) cnt = 4'($urandom_range(15, MAX_ARGS));
      return make_sig(s.return_type, cnt, s.varargs, a);
   endfunction

   function automatic sit_req_type fresh_signature();
      logic [3:0] cnt;
      cnt = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(MAX_ARGS));
      return make_sig(8'($urandom), cnt, 1'($urandom), {$urandom, $urandom});
   endfunction

   function automatic sit_req_type stored_signature(input int idx);
      return make_sig(known_header[idx][12:5], known_header[idx][4:1], known_header[idx][0],
                      known_args[idx]);
   endfunction

   // Mostly repeats of stored entries, some near misses, some brand-new ones.
   function automatic sit_req_type random_signature();
      sit_req_type       s;
      int                pick;
      int                lane;
      logic [3:0]        cnt;
      logic [ARGS_W-1:0] a;
      pick = $urandom_range(99);
      if (known_count == 0 || pick >= 85) return fresh_signature();
      s = stored_signature($urandom_range(known_count - 1));
      if (pick >= 70) begin
         cnt = s.param_count;
         a   = arg_lanes(s);
         case ($urandom_range(3))
            0: s.return_type[$urandom_range(7)] ^= 1'b1;
            1: s.param_count = 4'((cnt + 1 + $urandom_range(MAX_ARGS - 1)) % (MAX_ARGS + 1));
            2: s.varargs = ~s.varargs;
            default: begin
               if (cnt == 0) begin
                  s.varargs = ~s.varargs;
               end else begin
                  lane = $urandom_range(cnt - 1);
                  a[8*lane + $urandom_range(7)] ^= 1'b1;
                  s = make_sig(s.return_type, cnt, s.varargs, a);
               end
            end
         endcase
      end
      return add_lane_noise(s);
   endfunction

   task automatic send_signature(input sit_req_type s);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      pending_rsp_q.push_back(intern_signature(s));
      sent_total++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure and in-order comparison.
   always @(posedge clock) begin : check_results
      sit_rsp_type want;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         checked_total++;
         if (pending_rsp_q.size() == 0) begin
            if (error_count < 10)
               $display("%0t: unexpected transaction index=%0d full=%0b", $realtime,
                        rsp_payload.sig_index, rsp_payload.table_full);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_payload.sig_index !== want.sig_index ||
                rsp_payload.table_full !== want.table_full) begin
               if (error_count < 10)
                  $display("%0t: mismatch expected index=%0d full=%0b, got index=%0d full=%0b",
                           $realtime, want.sig_index, want.table_full,
                           rsp_payload.sig_index, rsp_payload.table_full);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_matching();
      send_signature(make_sig(8'h00, 4'd0, 1'b0, 64'h0));
      send_signature(make_sig(8'h00, 4'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd9, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd7, 1'b1, 64'h00FF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd8, 1'b1, 64'hFEFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'hFF, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FF00));
      send_signature(make_sig(8'h00, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_signature(make_sig(8'h7F, 4'd1, 1'b0, 64'h1234_5678_9ABC_DEAA));
      send_signature(make_sig(8'h7F, 4'd1, 1'b0, 64'h0000_0000_0000_00AA));
      send_signature(make_sig(8'h80, 4'd8, 1'b0, 64'h5555_5555_5555_5555));
      send_signature(make_sig(8'h80, 4'd8, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA));
      send_signature(make_sig(8'h80, 4'd12, 1'b0, 64'h5555_5555_5555_5555));
      send_signature(make_sig(8'h00, 4'd0, 1'b1, 64'h0));
      send_signature(make_sig(8'h00, 4'd0, 1'b0, 64'h0));
   endtask

   task automatic test_random_lookups(input int n);
      for (int k = 0; k < n; k++) send_signature(random_signature());
   endtask

   // Fill every free entry, then probe misses and the first and last entries.
   task automatic test_table_overflow();
      for (int k = 0; k < 4 * SIG_ENTRIES && known_count < SIG_ENTRIES; k++)
         send_signature(fresh_signature());
      for (int k = 0; k < 4; k++) send_signature(fresh_signature());
      send_signature(add_lane_noise(stored_signature(0)));
      send_signature(add_lane_noise(stored_signature(SIG_ENTRIES - 1)));
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      known_count   = 0;
      error_count   = 0;
      sent_total    = 0;
      hit_total     = 0;
      insert_total  = 0;
      full_total    = 0;
      checked_total = 0;
      send_idle_pct = 15;
      recv_idle_pct = 85;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_matching();
      test_random_lookups(590);
      wait_for_results();

      send_idle_pct = 85;
      recv_idle_pct = 15;
      test_random_lookups(590);
      test_table_overflow();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lookups(590);

      wait_for_results();
      repeat (2 * LOOKUP_CYCLES) @(posedge clock);

      $display("Sent %0d signatures: %0d found, %0d added, %0d refused on a full table.",
               sent_total, hit_total, insert_total, full_total);
      $display("Compared %0d transactions on the result side, %0d errors.",
               checked_total, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== signature_intern_table.f =====
+incdir+hw/rtl
hw/rtl/sit_pkg.sv
hw/rtl/sit_cell.sv
hw/rtl/signature_intern_table.sv
bench/testbench.sv
